// ----- hdl/mtd_pkg.sv -----
// Package with the token types, character codes and Morse lookup table.
`timescale 1ns / 1ps

package mtd_pkg;

    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    localparam int TABLE_SYMBOLS = 7;
    localparam int LEN_W = 4;

    typedef enum logic [2:0] {
        SYM_DOT,
        SYM_DASH,
        SYM_SLASH,
        SYM_BLANK,
        SYM_OTHER
    } sym_kind_t;

    // A finished token as handed from the front to the back.
    typedef struct packed {
        logic                     space;
        logic [LEN_W-1:0]         len;
        logic [TABLE_SYMBOLS-1:0] pat;
    } token_t;

    function automatic sym_kind_t classify(input logic [7:0] c);
        sym_kind_t k;
        unique case (c) inside
            CHAR_DOT:   k = SYM_DOT;
            CHAR_DASH:  k = SYM_DASH;
            CHAR_SLASH: k = SYM_SLASH;
            CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_VT, CHAR_FF, CHAR_CR: k = SYM_BLANK;
            default:    k = SYM_OTHER;
        endcase
        return k;
    endfunction

    // Symbol k of a token sits in bit k of the pattern, and a dash is a one.
    function automatic logic [7:0] lookup(input logic [LEN_W-1:0] len,
                                          input logic [TABLE_SYMBOLS-1:0] pat);
        logic [7:0] ch;
        unique case ({len, pat})
            {4'd2, 7'b0000010}: ch = 8'h41;
            {4'd4, 7'b0000001}: ch = 8'h42;
            {4'd4, 7'b0000101}: ch = 8'h43;
            {4'd3, 7'b0000001}: ch = 8'h44;
            {4'd1, 7'b0000000}: ch = 8'h45;
            {4'd4, 7'b0000100}: ch = 8'h46;
            {4'd3, 7'b0000011}: ch = 8'h47;
            {4'd4, 7'b0000000}: ch = 8'h48;
            {4'd2, 7'b0000000}: ch = 8'h49;
            {4'd4, 7'b0001110}: ch = 8'h4A;
            {4'd3, 7'b0000101}: ch = 8'h4B;
            {4'd4, 7'b0000010}: ch = 8'h4C;
            {4'd2, 7'b0000011}: ch = 8'h4D;
            {4'd2, 7'b0000001}: ch = 8'h4E;
            {4'd3, 7'b0000111}: ch = 8'h4F;
            {4'd4, 7'b0000110}: ch = 8'h50;
            {4'd4, 7'b0001011}: ch = 8'h51;
            {4'd3, 7'b0000010}: ch = 8'h52;
            {4'd3, 7'b0000000}: ch = 8'h53;
            {4'd1, 7'b0000001}: ch = 8'h54;
            {4'd3, 7'b0000100}: ch = 8'h55;
            {4'd4, 7'b0001000}: ch = 8'h56;
            {4'd3, 7'b0000110}: ch = 8'h57;
            {4'd4, 7'b0001001}: ch = 8'h58;
            {4'd4, 7'b0001101}: ch = 8'h59;
            {4'd4, 7'b0000011}: ch = 8'h5A;
            {4'd6, 7'b0101010}: ch = 8'h2E;
            {4'd6, 7'b0110011}: ch = 8'h2C;
            {4'd6, 7'b0001100}: ch = 8'h3F;
            {4'd6, 7'b0011110}: ch = 8'h27;
            {4'd6, 7'b0110101}: ch = 8'h21;
            {4'd5, 7'b0001001}: ch = 8'h2F;
            {4'd5, 7'b0001101}: ch = 8'h28;
            {4'd6, 7'b0101101}: ch = 8'h29;
            {4'd5, 7'b0000010}: ch = 8'h26;
            {4'd6, 7'b0000111}: ch = 8'h3A;
            {4'd6, 7'b0010101}: ch = 8'h3B;
            {4'd5, 7'b0010001}: ch = 8'h3D;
            {4'd5, 7'b0001010}: ch = 8'h2B;
            {4'd6, 7'b0100001}: ch = 8'h2D;
            {4'd6, 7'b0101100}: ch = 8'h5F;
            {4'd6, 7'b0010010}: ch = 8'h22;
            {4'd7, 7'b1001000}: ch = 8'h24;
            {4'd6, 7'b0010110}: ch = 8'h40;
            {4'd5, 7'b0011111}: ch = 8'h30;
            {4'd5, 7'b0011110}: ch = 8'h31;
            {4'd5, 7'b0011100}: ch = 8'h32;
            {4'd5, 7'b0011000}: ch = 8'h33;
            {4'd5, 7'b0010000}: ch = 8'h34;
            {4'd5, 7'b0000000}: ch = 8'h35;
            {4'd5, 7'b0000001}: ch = 8'h36;
            {4'd5, 7'b0000011}: ch = 8'h37;
            {4'd5, 7'b0000111}: ch = 8'h38;
            {4'd5, 7'b0001111}: ch = 8'h39;
            default:            ch = CHAR_SPACE;
        endcase
        return ch;
    endfunction

endpackage

// ----- hdl/mtd_front.sv -----
// Front end: takes input bytes, gathers the token and emits finished tokens.
`timescale 1ns / 1ps

module mtd_front #(
    parameter int MAX_SYMBOLS = 7
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_char,
    input  logic                in_last,
    output logic                tok_valid,
    input  logic                tok_ready,
    output mtd_pkg::token_t     tok_data
);

    localparam int IDX_W = $clog2(MAX_SYMBOLS);
    localparam logic [mtd_pkg::LEN_W-1:0] LEN_MAX = mtd_pkg::LEN_W'(MAX_SYMBOLS);

    logic [MAX_SYMBOLS-1:0]    pattern_reg, pattern_next, pattern_upd;
    logic [mtd_pkg::LEN_W-1:0] length_reg, length_next, length_upd;
    logic                      bad_reg, bad_next, bad_upd;
    logic                      slash_reg, slash_next, slash_upd;
    mtd_pkg::sym_kind_t        kind;
    logic                      accept;
    logic                      ends;
    logic                      pending;

    assign kind     = mtd_pkg::classify(in_char);
    assign in_ready = tok_ready;
    assign accept   = in_valid && in_ready;
    assign ends     = in_last || (kind == mtd_pkg::SYM_BLANK);

    always_comb begin
        pattern_upd = pattern_reg;
        length_upd  = length_reg;
        bad_upd     = bad_reg;
        slash_upd   = slash_reg;
        case (kind) inside
            mtd_pkg::SYM_DOT, mtd_pkg::SYM_DASH: begin
                if (slash_reg || length_reg >= LEN_MAX) begin
                    bad_upd = 1'b1;
                end else begin
                    if (kind == mtd_pkg::SYM_DASH) begin
                        pattern_upd[length_reg[IDX_W-1:0]] = 1'b1;
                    end
                    length_upd = length_reg + 1'b1;
                end
            end
            mtd_pkg::SYM_SLASH: begin
                if (length_reg == '0 && !bad_reg && !slash_reg) begin
                    slash_upd = 1'b1;
                end else begin
                    bad_upd = 1'b1;
                end
            end
            mtd_pkg::SYM_BLANK: begin
            end
            default: begin
                bad_upd = 1'b1;
            end
        endcase
    end

    assign pending = (length_upd != '0) || bad_upd || slash_upd;

    always_comb begin
        tok_valid     = in_valid && ends && pending;
        tok_data.space = bad_upd || slash_upd;
        tok_data.len   = length_upd;
        tok_data.pat   = pattern_upd[mtd_pkg::TABLE_SYMBOLS-1:0];
    end

    always_comb begin
        pattern_next = pattern_reg;
        length_next  = length_reg;
        bad_next     = bad_reg;
        slash_next   = slash_reg;
        if (accept) begin
            if (ends) begin
                pattern_next = '0;
                length_next  = '0;
                bad_next     = 1'b0;
                slash_next   = 1'b0;
            end else begin
                pattern_next = pattern_upd;
                length_next  = length_upd;
                bad_next     = bad_upd;
                slash_next   = slash_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            length_reg  <= '0;
            bad_reg     <= 1'b0;
            slash_reg   <= 1'b0;
        end else begin
            pattern_reg <= pattern_next;
            length_reg  <= length_next;
            bad_reg     <= bad_next;
            slash_reg   <= slash_next;
        end
    end

endmodule

// ----- hdl/mtd_queue.sv -----
// Two-entry token queue between the front end and the back end.
`timescale 1ns / 1ps

module mtd_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  mtd_pkg::token_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output mtd_pkg::token_t out_data
);

    mtd_pkg::token_t entries_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            push;
    logic            pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entries_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) count_reg != 2'd3)
        else $error("Token queue count went past its depth.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("Token queue lost a pushed word.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("Token queue pointers disagree with the count.");

endmodule

// ----- hdl/mtd_back.sv -----
// Back end: looks up the Morse table and holds the result in an output register.
`timescale 1ns / 1ps

module mtd_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            tok_valid,
    output logic            tok_ready,
    input  mtd_pkg::token_t tok_data,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_letter
);

    logic       valid_reg, valid_next;
    logic [7:0] letter_reg, letter_next;
    logic       take;

    assign tok_ready  = !valid_reg || out_ready;
    assign take       = tok_valid && tok_ready;
    assign out_valid  = valid_reg;
    assign out_letter = letter_reg;

    always_comb begin
        valid_next  = valid_reg;
        letter_next = letter_reg;
        if (take) begin
            valid_next  = 1'b1;
            letter_next = tok_data.space ? mtd_pkg::CHAR_SPACE
                                         : mtd_pkg::lookup(tok_data.len, tok_data.pat);
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        letter_reg <= letter_next;
    end

endmodule

// ----- hdl/morse_token_decoder.sv -----
// Top level of the Morse token decoder.
`timescale 1ns / 1ps

// The s_ channel takes one text byte per word: '.' and '-' build a token,
// '/' alone is a word gap, and whitespace ends the token. s_end_of_stream
// marks the last byte, after which any pending token is decoded.
// The m_ channel returns one ASCII character per non-empty token: the
// letter, digit or punctuation mark of the Morse pattern, or a space for
// a word gap or an unknown token. Empty tokens give no word.
// The block takes a byte in every cycle while the token queue is not full.
// Once the byte that ends a token is accepted, its result reaches m_ by
// way of the two-entry token queue and then the output register after the
// table lookup. When the receiver stalls, the output register holds its
// word and the queue absorbs up to two further tokens; s_ready falls only
// when the queue is full.
// A synchronous reset on aresetn clears the pending token, empties the
// queue and drops m_valid.

module morse_token_decoder #(
    parameter int MAX_SYMBOLS = 7
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_in,
    input  logic       s_end_of_stream,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_letter
);

    logic            fq_valid;
    logic            fq_ready;
    mtd_pkg::token_t fq_data;
    logic            qb_valid;
    logic            qb_ready;
    mtd_pkg::token_t qb_data;

    mtd_front #(
        .MAX_SYMBOLS(MAX_SYMBOLS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_char  (s_char_in),
        .in_last  (s_end_of_stream),
        .tok_valid(fq_valid),
        .tok_ready(fq_ready),
        .tok_data (fq_data)
    );

    mtd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (fq_valid),
        .in_ready (fq_ready),
        .in_data  (fq_data),
        .out_valid(qb_valid),
        .out_ready(qb_ready),
        .out_data (qb_data)
    );

    mtd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tok_valid (qb_valid),
        .tok_ready (qb_ready),
        .tok_data  (qb_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_letter(m_letter)
    );

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the Morse token decoder.
`timescale 1ns / 1ps

module tb;

    localparam int SYMBOL_LIMIT = 7;
    localparam int RANDOM_ITEMS = 1400;
    localparam int STREAM_ITEMS = 350;

    logic       aclk;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_char_in = 8'h00;
    logic       s_end_of_stream = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_letter;

    logic [7:0] letters_due[$];
    logic [6:0] tok_pat = '0;
    logic [3:0] tok_len = '0;
    logic       tok_bad = 1'b0;
    logic       tok_slash = 1'b0;

    logic [7:0] blanks[6] = '{mtd_pkg::CHAR_SPACE, mtd_pkg::CHAR_TAB, mtd_pkg::CHAR_LF,
                              mtd_pkg::CHAR_VT, mtd_pkg::CHAR_FF, mtd_pkg::CHAR_CR};

    int  fail_count = 0;
    int  sent = 0;
    int  stall_left = 0;
    bit  source_gaps = 1'b1;
    bit  sink_stalls = 1'b1;

    morse_token_decoder #(
        .MAX_SYMBOLS(SYMBOL_LIMIT)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_char_in(s_char_in),
        .s_end_of_stream(s_end_of_stream),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_letter(m_letter)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    function automatic logic [7:0] morse_letter(input logic [3:0] len, input logic [6:0] pat);
        string      code;
        logic [7:0] ch;
        code = "";
        for (int k = 0; k < len; k++) begin
            if (pat[k])
                code = {code, "-"};
            else
                code = {code, "."};
        end
        case (code)
            ".-":      ch = "A";
            "-...":    ch = "B";
            "-.-.":    ch = "C";
            "-..":     ch = "D";
            ".":       ch = "E";
            "..-.":    ch = "F";
            "--.":     ch = "G";
            "....":    ch = "H";
            "..":      ch = "I";
            ".---":    ch = "J";
            "-.-":     ch = "K";
            ".-..":    ch = "L";
            "--":      ch = "M";
            "-.":      ch = "N";
            "---":     ch = "O";
            ".--.":    ch = "P";
            "--.-":    ch = "Q";
            ".-.":     ch = "R";
            "...":     ch = "S";
            "-":       ch = "T";
            "..-":     ch = "U";
            "...-":    ch = "V";
            ".--":     ch = "W";
            "-..-":    ch = "X";
            "-.--":    ch = "Y";
            "--..":    ch = "Z";
            ".-.-.-":  ch = ".";
            "--..--":  ch = ",";
            "..--..":  ch = "?";
            ".----.":  ch = "'";
            "-.-.--":  ch = "!";
            "-..-.":   ch = "/";
            "-.--.":   ch = "(";
            "-.--.-":  ch = ")";
            ".-...":   ch = "&";
            "---...":  ch = ":";
            "-.-.-.":  ch = ";";
            "-...-":   ch = "=";
            ".-.-.":   ch = "+";
            "-....-":  ch = "-";
            "..--.-":  ch = "_";
            ".-..-.":  ch = "\"";
            "...-..-": ch = "$";
            ".--.-.":  ch = "@";
            "-----":   ch = "0";
            ".----":   ch = "1";
            "..---":   ch = "2";
            "...--":   ch = "3";
            "....-":   ch = "4";
            ".....":   ch = "5";
            "-....":   ch = "6";
            "--...":   ch = "7";
            "---..":   ch = "8";
            "----.":   ch = "9";
            default:   ch = mtd_pkg::CHAR_SPACE;
        endcase
        return ch;
    endfunction

    task automatic feed_char(input logic [7:0] c, input logic last);
        logic ends;
        ends = last;
        if (c == mtd_pkg::CHAR_SPACE || (c >= mtd_pkg::CHAR_TAB && c <= mtd_pkg::CHAR_CR)) begin
            ends = 1'b1;
        end else if (c == mtd_pkg::CHAR_DOT || c == mtd_pkg::CHAR_DASH) begin
            if (tok_slash || tok_len >= SYMBOL_LIMIT) begin
                tok_bad = 1'b1;
            end else begin
                if (c == mtd_pkg::CHAR_DASH)
                    tok_pat[tok_len] = 1'b1;
                tok_len++;
            end
        end else if (c == mtd_pkg::CHAR_SLASH) begin
            if (tok_len == 0 && !tok_bad && !tok_slash)
                tok_slash = 1'b1;
            else
                tok_bad = 1'b1;
        end else begin
            tok_bad = 1'b1;
        end
        if (ends) begin
            if (tok_len != 0 || tok_bad || tok_slash)
                letters_due.push_back((tok_bad || tok_slash) ? mtd_pkg::CHAR_SPACE
                                                             : morse_letter(tok_len, tok_pat));
            tok_pat = '0;
            tok_len = '0;
            tok_bad = 1'b0;
            tok_slash = 1'b0;
        end
    endtask

    task automatic send_char(input logic [7:0] c, input logic last);
        if (source_gaps && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_char_in <= c;
        s_end_of_stream <= last;
        do @(posedge aclk); while (!s_ready);
        feed_char(c, last);
        sent++;
    endtask

    task automatic send_text(input string text, input logic last_on_final);
        for (int i = 0; i < text.len(); i++)
            send_char(text[i], last_on_final && i == text.len() - 1);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (letters_due.size() != 0);
    endtask

    function automatic logic [7:0] pick_blank();
        return blanks[$urandom_range(0, 5)];
    endfunction

    function automatic string random_symbols(input int n);
        string sym;
        sym = "";
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 1))
                sym = {sym, "-"};
            else
                sym = {sym, "."};
        end
        return sym;
    endfunction

    task automatic end_token(input string body);
        logic last;
        last = ($urandom_range(0, 9) == 0);
        if (last && $urandom_range(0, 1)) begin
            send_text(body, 1'b1);
        end else begin
            send_text(body, 1'b0);
            send_char(pick_blank(), last);
        end
    endtask

    task automatic send_random_token();
        int kind;
        int len;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 6);
            end_token(random_symbols(len));
        end else if (kind < 80) begin
            case ($urandom_range(0, 3))
                0: end_token("/");
                1: end_token("//");
                2: end_token({"/", random_symbols($urandom_range(1, 3))});
                default: end_token({random_symbols($urandom_range(1, 3)), "/"});
            endcase
        end else if (kind < 92) begin
            send_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end else begin
            repeat ($urandom_range(1, 3)) send_char(pick_blank(), $urandom_range(0, 7) == 0);
        end
    endtask

    task automatic test_special_tokens();
        send_text(".-", 1'b0);
        send_char(mtd_pkg::CHAR_TAB, 1'b0);
        send_char(mtd_pkg::CHAR_SLASH, 1'b0);
        send_char(mtd_pkg::CHAR_LF, 1'b0);
        send_text("...-..-", 1'b1);
        send_text("--------", 1'b0);
        send_char(mtd_pkg::CHAR_VT, 1'b0);
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b0);
        send_char(mtd_pkg::CHAR_FF, 1'b0);
        send_text("./", 1'b1);
        send_char(mtd_pkg::CHAR_DOT, 1'b0);
        send_char(mtd_pkg::CHAR_SPACE, 1'b1);
        send_char(mtd_pkg::CHAR_CR, 1'b1);
        send_char(mtd_pkg::CHAR_CR, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int next_shuffle;
        next_shuffle = sent + 100;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= next_shuffle) begin
                next_shuffle += 100;
                source_gaps = ($urandom_range(0, 3) != 0);
                sink_stalls = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 3) == 0)
                    wait_drained();
            end
            send_random_token();
        end
    endtask

    task automatic test_streaming();
        int stop_at;
        stop_at = sent + STREAM_ITEMS;
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
        while (sent < stop_at)
            send_random_token();
    endtask

    always @(posedge aclk) begin
        if (stall_left == 0 && sink_stalls && $urandom_range(0, 11) == 0)
            stall_left = $urandom_range(1, 17);
        if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (letters_due.size() == 0) begin
                $error("letter: no word expected, got %h", m_letter);
                fail_count++;
            end else begin
                if (m_letter !== letters_due[0]) begin
                    $error("letter: expected %h, got %h", letters_due[0], m_letter);
                    fail_count++;
                end
                void'(letters_due.pop_front());
            end
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_special_tokens();
        test_random_traffic();
        test_streaming();
        s_valid <= 1'b0;
        while (letters_due.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("morse_token_decoder regression: pass");
        else
            $display("morse_token_decoder regression: fail");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("morse_token_decoder regression: fail");
        $finish;
    end

endmodule

// ----- morse_token_decoder.f -----
hdl/mtd_pkg.sv
hdl/mtd_front.sv
hdl/mtd_queue.sv
hdl/mtd_back.sv
hdl/morse_token_decoder.sv
verif/tb.sv
